>>> rtl/varint_event_stream_decoder_defines.svh
// assertion macros used by vesd_core
`ifndef VARINT_EVENT_STREAM_DECODER_DEFINES_SVH
`define VARINT_EVENT_STREAM_DECODER_DEFINES_SVH

`ifndef SYNTHESIS

`define VESD_ASSERT_IMPL(label, cond_a, cond_c) \
  label: assert property (@(posedge clk) disable iff (rst) (cond_a) |-> (cond_c)) \
    else $error("vesd assertion failed");

`define VESD_ASSERT_NEXT(label, cond_a, cond_c) \
  label: assert property (@(posedge clk) disable iff (rst) (cond_a) |=> (cond_c)) \
    else $error("vesd assertion failed");

`else

`define VESD_ASSERT_IMPL(label, cond_a, cond_c)

`define VESD_ASSERT_NEXT(label, cond_a, cond_c)

`endif

`endif

>>> rtl/vesd_pkg.sv
`timescale 1ns / 1ps

package vesd_pkg;

  localparam int CMD_W      = 2;
  localparam int BYTE_W     = 8;
  localparam int TAIL_DUR_W = 45;
  localparam int LEVEL_W    = 4;
  localparam int OUT_TIME_W = 48;
  localparam int GROUP_W    = 7;
  localparam int CONT_BIT   = 7;
  localparam int IN_DATA_W  = 64;
  localparam int OUT_DATA_W = 112;

  localparam logic [CMD_W-1:0] CMD_DATA    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_TAIL    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RESTART = 2'd2;

  typedef struct packed {
    logic [CMD_W-1:0]      cmd;
    logic [BYTE_W-1:0]     data_byte;
    logic [TAIL_DUR_W-1:0] tail_duration;
    logic [LEVEL_W-1:0]    tail_levels;
  } item_t;

  typedef struct packed {
    logic [OUT_TIME_W-1:0] start_time;
    logic [OUT_TIME_W-1:0] end_time;
    logic [LEVEL_W-1:0]    levels;
    logic [LEVEL_W-1:0]    prior_levels;
    logic                  nonempty;
    logic                  refused;
    logic                  overflow;
  } result_t;

endpackage

>>> rtl/vesd_core.sv
`timescale 1ns / 1ps
`include "varint_event_stream_decoder_defines.svh"

module vesd_core
  import vesd_pkg::*;
#(
  parameter int TIME_WIDTH = 48,
  parameter int MAX_GROUPS = 7
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    advance,
  input  item_t   item,
  output logic    has_result,
  output result_t res
);

  localparam int WORD_W = GROUP_W * MAX_GROUPS;
  localparam int CNT_W  = $clog2(MAX_GROUPS + 1);

  logic [WORD_W-1:0]     word_accum;
  logic [CNT_W-1:0]      group_count;
  logic                  group_overflow;
  logic [TIME_WIDTH-1:0] last_end_time;
  logic [LEVEL_W-1:0]    last_levels;
  logic                  stream_closed;

  logic [WORD_W-1:0]     word_ins;
  logic                  group_full;
  logic                  is_data;
  logic                  is_tail;
  logic [TIME_WIDTH-1:0] duration;
  logic [TIME_WIDTH-1:0] end_calc;
  logic                  nonempty;
  logic [LEVEL_W-1:0]    new_levels;

  always_comb begin
    word_ins = word_accum;
    for (int g = 0; g < MAX_GROUPS; g++) begin
      if (group_count == CNT_W'(g)) begin
        word_ins[GROUP_W*g +: GROUP_W] = item.data_byte[GROUP_W-1:0];
      end
    end
  end

  assign group_full = (group_count == CNT_W'(MAX_GROUPS));
  assign is_data    = (item.cmd == CMD_DATA);
  assign is_tail    = (item.cmd == CMD_TAIL);
  assign duration   = is_tail ? TIME_WIDTH'(item.tail_duration)
                              : TIME_WIDTH'(word_ins >> LEVEL_W);
  assign end_calc   = last_end_time + duration;
  assign nonempty   = (last_end_time < end_calc);
  assign new_levels = is_tail ? item.tail_levels : word_ins[LEVEL_W-1:0];

  assign has_result = is_tail || (is_data && (stream_closed || !item.data_byte[CONT_BIT]));

  always_comb begin
    res.start_time   = OUT_TIME_W'(last_end_time);
    res.prior_levels = last_levels;
    if (stream_closed) begin
      res.end_time = OUT_TIME_W'(last_end_time);
      res.levels   = last_levels;
      res.nonempty = 1'b0;
      res.refused  = 1'b1;
      res.overflow = 1'b0;
    end else begin
      res.end_time = OUT_TIME_W'(end_calc);
      res.levels   = new_levels;
      res.nonempty = nonempty;
      res.refused  = 1'b0;
      res.overflow = is_data && (group_overflow || group_full);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word_accum     <= '0;
      group_count    <= '0;
      group_overflow <= 1'b0;
      last_end_time  <= '0;
      last_levels    <= '0;
      stream_closed  <= 1'b0;
    end else if (advance) begin
      case (item.cmd)
        CMD_RESTART: begin
          word_accum     <= '0;
          group_count    <= '0;
          group_overflow <= 1'b0;
          last_end_time  <= '0;
          last_levels    <= '0;
          stream_closed  <= 1'b0;
        end
        CMD_DATA: begin
          if (!stream_closed) begin
            if (item.data_byte[CONT_BIT]) begin
              word_accum <= word_ins;
              if (group_full) begin
                group_overflow <= 1'b1;
              end else begin
                group_count <= group_count + CNT_W'(1);
              end
            end else begin
              word_accum     <= '0;
              group_count    <= '0;
              group_overflow <= 1'b0;
              last_end_time  <= end_calc;
              last_levels    <= new_levels;
            end
          end
        end
        CMD_TAIL: begin
          if (!stream_closed) begin
            word_accum     <= '0;
            group_count    <= '0;
            group_overflow <= 1'b0;
            last_end_time  <= end_calc;
            last_levels    <= new_levels;
            stream_closed  <= nonempty;
          end
        end
        default: begin
        end
      endcase
    end
  end

  `VESD_ASSERT_IMPL(a_count_bound, 1'b1, group_count <= CNT_W'(MAX_GROUPS))
  `VESD_ASSERT_IMPL(a_closed_refuses,
                    advance && stream_closed && (is_data || is_tail),
                    has_result && res.refused)
  `VESD_ASSERT_NEXT(a_restart_clears,
                    advance && item.cmd == CMD_RESTART,
                    last_end_time == '0 && !stream_closed && group_count == '0)
  `VESD_ASSERT_NEXT(a_tail_closes,
                    advance && is_tail && !stream_closed && nonempty,
                    stream_closed)

endmodule

>>> rtl/varint_event_stream_decoder.sv
// channel  dir  signals                  content
// s        in   tvalid tready tdata tuser  one command with its byte or tail event
// m        out  tvalid tready tdata        one decoded event
//
// one item per cycle unless m_tready stalls a result; s to m via input then output register
// the input register absorbs one request while a result waits in the output register
// every word bit is decoded by one pass of shift-free group select, a time adder and compare
// rst is synchronous and clears the stream state to time zero and open
// continuation bytes on an open stream, restart and unused commands never wait on m_tready
`timescale 1ns / 1ps

module varint_event_stream_decoder
  import vesd_pkg::*;
#(
  parameter int TIME_WIDTH = 48,
  parameter int MAX_GROUPS = 7
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // data_byte[7:0], tail_duration[52:8], tail_levels[56:53], zero fill
  input  logic [IN_DATA_W-1:0]  s_tdata,
  // cmd[1:0]
  input  logic [CMD_W-1:0]      s_tuser,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // start_time[47:0], end_time[95:48], levels[99:96], prior_levels[103:100],
  // nonempty[104], refused[105], overflow[106], zero fill
  output logic [OUT_DATA_W-1:0] m_tdata
);

  logic    in_valid;
  item_t   in_item;
  logic    out_valid;
  result_t out_res;
  logic    advance;
  logic    has_result;
  result_t res;

  vesd_core #(
    .TIME_WIDTH(TIME_WIDTH),
    .MAX_GROUPS(MAX_GROUPS)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .item      (in_item),
    .has_result(has_result),
    .res       (res)
  );

  assign advance  = in_valid && (!has_result || !out_valid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_item.cmd           <= s_tuser;
      in_item.data_byte     <= s_tdata[7:0];
      in_item.tail_duration <= s_tdata[52:8];
      in_item.tail_levels   <= s_tdata[56:53];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && has_result) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && has_result) begin
      out_res <= res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {5'b0, out_res.overflow, out_res.refused, out_res.nonempty,
                     out_res.prior_levels, out_res.levels, out_res.end_time,
                     out_res.start_time};

endmodule
